/* src/pis_pkg.sv */
package pis_pkg;

  typedef enum logic [2:0] {
    FUNC_PUSH          = 3'd0,
    FUNC_POP           = 3'd1,
    FUNC_DROP          = 3'd2,
    FUNC_REMOVE_BOTTOM = 3'd3,
    FUNC_REVERSE       = 3'd4,
    FUNC_CLEAR         = 3'd5,
    FUNC_STATUS        = 3'd6
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_WALK,
    ST_PUSH_PUT,
    ST_RB_WALK,
    ST_REV_A,
    ST_REV_B,
    ST_RD_TOP,
    ST_RD_BOT,
    ST_LOAD
  } state_e;

  localparam int unsigned FUNC_BITS = 3;
  localparam int unsigned IN_DATA_BITS = 24;
  localparam int unsigned OUT_DATA_BITS = 48;
  localparam int unsigned PORT_ID_BITS = 16;
  localparam int unsigned PORT_CNT_BITS = 7;

endpackage

/* src/priority_insert_stack_top.sv */
// Bounded stack of client entries (id and registered flag) held in a single
// synchronous RAM with one read and one write port. Pushing a registered
// client puts it on top; an unregistered one is slipped beneath the run of
// registered entries at the top. One result item follows every input item,
// giving top, bottom, count, empty and push-rejected after the operation.
// Push onto top, pop, drop, clear and status go straight to reading the top
// and bottom entries and loading the result; an unregistered push first moves
// each registered entry of the top run up one slot, remove-bottom first shifts
// the stack down by one, and reverse first swaps the entries pair by pair.
// These walks go through the single read port of the entry RAM, walking the
// stack one entry per cycle. A new item is taken
// while the previous result still waits in the output register; the next
// result then stalls until that register is free.
module priority_insert_stack_top #(
  parameter int unsigned DEPTH   = 64,
  parameter int unsigned ID_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // client_id[15:0], registered[16], drop_count[23:17]
  input  logic [pis_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  // func[2:0]
  input  logic [pis_pkg::FUNC_BITS-1:0]     s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // top_id[15:0], top_registered[16], bottom_id[32:17], bottom_registered[33],
  // entry_count[40:34], is_empty[41], push_rejected[42], zero[47:43]
  output logic [pis_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > pis_pkg::PORT_CNT_BITS) ? CW : pis_pkg::PORT_CNT_BITS;
  localparam int unsigned EW = ID_BITS + 1;

  pis_pkg::state_e state_q, state_d;
  pis_pkg::func_e  func;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [AW-1:0] lo_q, lo_d;
  logic [AW-1:0] hi_q, hi_d;
  logic          pend_q, pend_d;
  logic [EW-1:0] new_q, new_d;
  logic          rej_q, rej_d;
  logic [EW-1:0] top_q, top_d;
  logic          out_valid_q, out_valid_d;
  logic [pis_pkg::OUT_DATA_BITS-1:0] out_data_q, out_data_d;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic          in_acc;
  logic [EW-1:0] in_entry;
  logic [pis_pkg::PORT_ID_BITS-1:0]  in_id;
  logic [pis_pkg::PORT_CNT_BITS-1:0] in_drop;
  logic          in_reg;
  logic [AW-1:0] top_addr;
  logic          empty;

  assign in_id   = s_axis_tdata[15:0];
  assign in_reg  = s_axis_tdata[16];
  assign in_drop = s_axis_tdata[23:17];
  assign func    = pis_pkg::func_e'(s_axis_tuser);

  assign in_entry = {in_reg, ID_BITS'(in_id)};
  assign s_axis_tready = (state_q == pis_pkg::ST_IDLE);
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign empty    = (cnt_q == '0);
  assign top_addr = empty ? '0 : AW'(cnt_q - 1'b1);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pend_d      = pend_q;
    new_d       = new_q;
    rej_d       = rej_q;
    top_d       = top_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;
    rd_addr     = '0;
    we          = 1'b0;
    wr_addr     = '0;
    wr_data     = rd_q;

    case (state_q)
      pis_pkg::ST_IDLE: begin
        rd_addr = (func == pis_pkg::FUNC_REMOVE_BOTTOM) ? AW'(1) : top_addr;
        if (in_acc) begin
          rej_d   = 1'b0;
          state_d = pis_pkg::ST_RD_TOP;
          case (func)
            pis_pkg::FUNC_PUSH: begin
              if (cnt_q == CW'(DEPTH)) begin
                rej_d = 1'b1;
              end else begin
                cnt_d = cnt_q + 1'b1;
                new_d = in_entry;
                if (in_reg || empty) begin
                  we      = 1'b1;
                  wr_addr = AW'(cnt_q);
                  wr_data = in_entry;
                end else begin
                  idx_d   = cnt_q;
                  state_d = pis_pkg::ST_PUSH_WALK;
                end
              end
            end
            pis_pkg::FUNC_POP: begin
              if (!empty) begin
                cnt_d = cnt_q - 1'b1;
              end
            end
            pis_pkg::FUNC_DROP: begin
              if (XW'(in_drop) >= XW'(cnt_q)) begin
                cnt_d = '0;
              end else begin
                cnt_d = cnt_q - CW'(in_drop);
              end
            end
            pis_pkg::FUNC_REMOVE_BOTTOM: begin
              if (!empty) begin
                cnt_d = cnt_q - 1'b1;
              end
              if (cnt_q >= CW'(2)) begin
                idx_d   = CW'(1);
                state_d = pis_pkg::ST_RB_WALK;
              end
            end
            pis_pkg::FUNC_REVERSE: begin
              if (cnt_q >= CW'(2)) begin
                lo_d    = '0;
                hi_d    = top_addr;
                pend_d  = 1'b0;
                state_d = pis_pkg::ST_REV_A;
              end
            end
            pis_pkg::FUNC_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // rd_q holds the entry just below the slot at idx_q
      pis_pkg::ST_PUSH_WALK: begin
        we      = 1'b1;
        wr_addr = AW'(idx_q);
        if (rd_q[EW-1]) begin
          wr_data = rd_q;
          idx_d   = idx_q - 1'b1;
          if (idx_q > CW'(1)) begin
            rd_addr = AW'(idx_q - CW'(2));
          end else begin
            state_d = pis_pkg::ST_PUSH_PUT;
          end
        end else begin
          wr_data = new_q;
          state_d = pis_pkg::ST_RD_TOP;
        end
      end

      pis_pkg::ST_PUSH_PUT: begin
        we      = 1'b1;
        wr_addr = AW'(idx_q);
        wr_data = new_q;
        state_d = pis_pkg::ST_RD_TOP;
      end

      // shift every entry down by one; rd_q holds entry idx_q
      pis_pkg::ST_RB_WALK: begin
        we      = 1'b1;
        wr_addr = AW'(idx_q - 1'b1);
        if (idx_q < cnt_q) begin
          rd_addr = AW'(idx_q + 1'b1);
          idx_d   = idx_q + 1'b1;
        end else begin
          state_d = pis_pkg::ST_RD_TOP;
        end
      end

      // rd_q holds the old upper entry of the previous pair
      pis_pkg::ST_REV_A: begin
        wr_addr = lo_q - 1'b1;
        if (hi_q > lo_q) begin
          rd_addr = lo_q;
          we      = pend_q;
          state_d = pis_pkg::ST_REV_B;
        end else begin
          we      = 1'b1;
          state_d = pis_pkg::ST_RD_TOP;
        end
      end

      // read-first: the old upper entry is read while the lower one lands
      pis_pkg::ST_REV_B: begin
        rd_addr = hi_q;
        we      = 1'b1;
        wr_addr = hi_q;
        lo_d    = lo_q + 1'b1;
        hi_d    = hi_q - 1'b1;
        pend_d  = 1'b1;
        state_d = pis_pkg::ST_REV_A;
      end

      pis_pkg::ST_RD_TOP: begin
        rd_addr = top_addr;
        state_d = pis_pkg::ST_RD_BOT;
      end

      pis_pkg::ST_RD_BOT: begin
        top_d   = rd_q;
        state_d = pis_pkg::ST_LOAD;
      end

      pis_pkg::ST_LOAD: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          if (empty) begin
            out_data_d = {5'b0, rej_q, 1'b1, 7'b0, 1'b0, 16'b0, 1'b0, 16'b0};
          end else begin
            out_data_d = {5'b0, rej_q, 1'b0,
                          pis_pkg::PORT_CNT_BITS'(cnt_q),
                          rd_q[EW-1], pis_pkg::PORT_ID_BITS'(rd_q[ID_BITS-1:0]),
                          top_q[EW-1], pis_pkg::PORT_ID_BITS'(top_q[ID_BITS-1:0])};
          end
          state_d = pis_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = pis_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pis_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    pend_q     <= pend_d;
    new_q      <= new_d;
    rej_q      <= rej_d;
    top_q      <= top_d;
    out_data_q <= out_data_d;
  end

endmodule
